// ===== rtl/fikl_pkg.sv =====
// Package: shared types, constants and status codes for the key lookup core.
`timescale 1ns / 1ps
package fikl_pkg;
  localparam int MAX_ENTRIES = 1024;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int BUCKETS = 256;
  localparam int BKT_W = 8;
  localparam int KEY_W = 256;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_ORDER    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_RANGE    = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic clear;      // drop all entries
    logic rd_last;    // read entry count-1
    logic rd_bucket;  // read bucket bounds
    logic rd_mid;     // read midpoint of search window
    logic rd_idx;     // read requested index
    logic init_win;   // load search window from bucket bounds
    logic step_win;   // narrow window from comparison
    logic write;      // store new entry
    logic res_load;   // capture result
    logic [2:0] res_status;
    logic res_sel_mid;  // result index from midpoint
    logic res_sel_last; // result index from last entry
    logic res_sel_cnt;  // result index from entry count (insert)
    logic res_sel_idx;  // result index/key from read index
  } fikl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic empty;
    logic full;
    logic cmp_eq;
    logic cmp_lt;
    logic bucket_used;
    logic win_empty;
    logic idx_range;
  } fikl_stat_t;
endpackage

// ===== rtl/fanout_indexed_key_lookup_core.sv =====
// Top level: sorted 256-bit key index with fanout table and bucket binary search.
//
// One command word enters on s_axis and one result word leaves on m_axis.
// Commands: clear, insert (keys in strictly ascending order), lookup by key,
// read by index. A lookup takes the bucket from the key's top byte and
// binary searches inside that bucket; each probe is a memory read and
// then a compare.
// One command is in flight at a time; s_axis_tready is high only while
// the block is idle, so a new command waits until the result is taken.
// The result is held in a register until m_axis_tready; a stalled
// receiver holds the block and no new word is taken.
// Reset empties the table (entry count and bucket flags cleared); key
// and offset memories are not cleared and need no sweep.
`timescale 1ns / 1ps
module fanout_indexed_key_lookup_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0], key_word0[65:2], key_word1[129:66], key_word2[193:130],
  // key_word3[257:194], entry_offset[289:258], entry_index[299:290]
  input  logic [303:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], found_index[12:3], found_offset[44:13], out_key_word0[108:45],
  // out_key_word1[172:109], out_key_word2[236:173], out_key_word3[300:237]
  output logic [303:0] m_axis_tdata
);
  fikl_pkg::fikl_cmd_t  cmd;
  fikl_pkg::fikl_stat_t stat;
  logic [2:0]   res_status;
  logic [9:0]   res_index;
  logic [31:0]  res_offset;
  logic [255:0] res_key;
  logic [255:0] in_key;

  assign in_key = {s_axis_tdata[65:2], s_axis_tdata[129:66],
                   s_axis_tdata[193:130], s_axis_tdata[257:194]};

  fikl_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .stat(stat), .cmd(cmd)
  );

  fikl_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_command(s_axis_tdata[1:0]), .in_key(in_key),
    .in_offset(s_axis_tdata[289:258]), .in_index(s_axis_tdata[299:290]),
    .res_status(res_status), .res_index(res_index),
    .res_offset(res_offset), .res_key(res_key)
  );

  assign m_axis_tdata = {3'b000, res_key[63:0], res_key[127:64], res_key[191:128],
                         res_key[255:192], res_offset, res_index, res_status};

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= fikl_pkg::ST_RANGE)
    else $error("bad status");
endmodule

// ===== rtl/fikl_datapath.sv =====
// Datapath: key and offset memories, fanout table, search window, result register.
`timescale 1ns / 1ps
module fikl_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  fikl_pkg::fikl_cmd_t            cmd,
  output fikl_pkg::fikl_stat_t           stat,
  input  logic [1:0]                     in_command,
  input  logic [fikl_pkg::KEY_W-1:0]     in_key,
  input  logic [31:0]                    in_offset,
  input  logic [9:0]                     in_index,
  output logic [2:0]                     res_status,
  output logic [9:0]                     res_index,
  output logic [31:0]                    res_offset,
  output logic [fikl_pkg::KEY_W-1:0]     res_key
);
  localparam int IW = fikl_pkg::IDX_W;
  localparam int CW = fikl_pkg::CNT_W;

  logic [fikl_pkg::KEY_W-1:0] key_mem [fikl_pkg::MAX_ENTRIES];
  logic [31:0]                off_mem [fikl_pkg::MAX_ENTRIES];
  logic [IW-1:0]              bfirst_mem [fikl_pkg::BUCKETS];
  logic [IW-1:0]              blast_mem  [fikl_pkg::BUCKETS];
  logic [fikl_pkg::BUCKETS-1:0] bucket_used;

  logic [1:0]                 command;
  logic [fikl_pkg::KEY_W-1:0] key;
  logic [31:0]                offset;
  logic [9:0]                 index;
  logic [CW-1:0]              entry_count;
  logic [CW-1:0]              lo, hi;
  logic [fikl_pkg::KEY_W-1:0] rd_key;
  logic [31:0]                rd_off;
  logic [IW-1:0]              rd_addr, rd_addr_next;
  logic [IW-1:0]              bfirst, blast;
  logic [CW-1:0]              mid;
  logic [CW-1:0]              hi_init;
  logic [fikl_pkg::BKT_W-1:0] bkt;

  assign bkt = key[fikl_pkg::KEY_W-1 -: fikl_pkg::BKT_W];
  assign mid = lo + ((hi - lo) >> 1);

  always_comb begin
    rd_addr_next = rd_addr;
    if (cmd.rd_last) rd_addr_next = IW'(entry_count - CW'(1));
    else if (cmd.rd_mid) rd_addr_next = mid[IW-1:0];
    else if (cmd.rd_idx) rd_addr_next = IW'(index);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command <= in_command;
      key <= in_key;
      offset <= in_offset;
      index <= in_index;
    end
    if (cmd.write) begin
      key_mem[entry_count[IW-1:0]] <= key;
      off_mem[entry_count[IW-1:0]] <= offset;
      blast_mem[bkt] <= entry_count[IW-1:0];
      if (!bucket_used[bkt]) bfirst_mem[bkt] <= entry_count[IW-1:0];
    end
    if (cmd.rd_last || cmd.rd_mid || cmd.rd_idx) begin
      rd_key <= key_mem[rd_addr_next];
      rd_off <= off_mem[rd_addr_next];
      rd_addr <= rd_addr_next;
    end
    if (cmd.rd_bucket) begin
      bfirst <= bfirst_mem[bkt];
      blast <= blast_mem[bkt];
    end
  end

  always_comb begin
    hi_init = CW'(blast) + CW'(1);
    if (hi_init > entry_count) hi_init = entry_count;
  end

  always_ff @(posedge clk) begin
    if (cmd.init_win) begin
      lo <= CW'(bfirst);
      hi <= hi_init;
    end else if (cmd.step_win) begin
      // key above probe: raise lower bound
      if (!stat.cmp_lt) lo <= CW'(rd_addr) + CW'(1);
      else hi <= CW'(rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      bucket_used <= '0;
    end else if (cmd.clear) begin
      entry_count <= '0;
      bucket_used <= '0;
    end else if (cmd.write) begin
      entry_count <= entry_count + CW'(1);
      bucket_used[bkt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_index <= '0;
      res_offset <= '0;
      res_key <= '0;
      if (cmd.res_sel_mid || cmd.res_sel_last) begin
        res_index <= 10'(rd_addr);
        res_offset <= rd_off;
      end else if (cmd.res_sel_cnt) begin
        res_index <= 10'(entry_count);
        res_offset <= offset;
      end else if (cmd.res_sel_idx) begin
        res_index <= 10'(rd_addr);
        res_offset <= rd_off;
        res_key <= rd_key;
      end
    end
  end

  always_comb begin
    stat.command = command;
    stat.empty = (entry_count == '0);
    stat.full = (entry_count >= CW'(fikl_pkg::MAX_ENTRIES));
    stat.cmp_eq = (key == rd_key);
    stat.cmp_lt = (key < rd_key);
    stat.bucket_used = bucket_used[bkt];
    stat.win_empty = !(lo < hi);
    stat.idx_range = (CW'(index) >= entry_count);
  end
endmodule

// ===== rtl/fikl_ctrl.sv =====
// Controller: sequences clear, insert, lookup search and indexed read.
`timescale 1ns / 1ps
module fikl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  fikl_pkg::fikl_stat_t  stat,
  output fikl_pkg::fikl_cmd_t   cmd
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_INSCMP = 3'd2;
  localparam logic [2:0] S_BKT    = 3'd3;
  localparam logic [2:0] S_PROBE  = 3'd4;
  localparam logic [2:0] S_CMP    = 3'd5;
  localparam logic [2:0] S_RDDONE = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_DEC;
      end
      S_DEC: begin
        state_next = S_OUT;
        cmd.res_load = 1'b1;
        case (stat.command)
          fikl_pkg::CMD_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.res_status = fikl_pkg::ST_OK;
          end
          fikl_pkg::CMD_INSERT: begin
            if (stat.empty) begin
              cmd.write = 1'b1;
              cmd.res_status = fikl_pkg::ST_OK;
              cmd.res_sel_cnt = 1'b1;
            end else begin
              cmd.res_load = 1'b0;
              cmd.rd_last = 1'b1;
              state_next = S_INSCMP;
            end
          end
          fikl_pkg::CMD_LOOKUP: begin
            if (!stat.bucket_used) begin
              cmd.res_status = fikl_pkg::ST_NOTFOUND;
            end else begin
              cmd.res_load = 1'b0;
              cmd.rd_bucket = 1'b1;
              state_next = S_BKT;
            end
          end
          default: begin
            if (stat.idx_range) begin
              cmd.res_status = fikl_pkg::ST_RANGE;
            end else begin
              cmd.res_load = 1'b0;
              cmd.rd_idx = 1'b1;
              state_next = S_RDDONE;
            end
          end
        endcase
      end
      S_INSCMP: begin
        cmd.res_load = 1'b1;
        state_next = S_OUT;
        if (stat.cmp_eq) begin
          cmd.res_status = fikl_pkg::ST_DUP;
          cmd.res_sel_last = 1'b1;
        end else if (stat.cmp_lt) begin
          cmd.res_status = fikl_pkg::ST_ORDER;
        end else if (stat.full) begin
          cmd.res_status = fikl_pkg::ST_FULL;
        end else begin
          cmd.write = 1'b1;
          cmd.res_status = fikl_pkg::ST_OK;
          cmd.res_sel_cnt = 1'b1;
        end
      end
      S_BKT: begin
        cmd.init_win = 1'b1;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        if (stat.win_empty) begin
          cmd.res_load = 1'b1;
          cmd.res_status = fikl_pkg::ST_NOTFOUND;
          state_next = S_OUT;
        end else begin
          cmd.rd_mid = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.cmp_eq) begin
          cmd.res_load = 1'b1;
          cmd.res_status = fikl_pkg::ST_OK;
          cmd.res_sel_mid = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.step_win = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_RDDONE: begin
        cmd.res_load = 1'b1;
        cmd.res_status = fikl_pkg::ST_OK;
        cmd.res_sel_idx = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
